### rtl/core/command_frame_parser_responder_assert.svh
// Assertion macros for the command frame parser and responder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef COMMAND_FRAME_PARSER_RESPONDER_ASSERT_SVH
`define COMMAND_FRAME_PARSER_RESPONDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CFPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cfpr_pkg.sv
// Shared types and constants for the command frame parser and responder.
// No dependencies.
`timescale 1ns / 1ps

package cfpr_pkg;

  localparam int WIN_DEPTH   = 5;
  localparam int FILL_W      = 3;
  localparam int FRAME_LEN   = 24;
  localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
  localparam int QUEUE_DEPTH = 4;
  localparam int GOAL_W      = 18;

  localparam logic [7:0] SOF_BYTE   = 8'hFD;
  localparam logic [7:0] EOF_BYTE   = 8'hA5;
  localparam logic [7:0] RSP_SOF    = 8'hFE;
  localparam logic [7:0] CODE_OPEN  = 8'h01;
  localparam logic [7:0] CODE_CLOSE = 8'h05;

  localparam logic [7:0] CMD_OPEN  = 8'h00;
  localparam logic [7:0] CMD_SEND  = 8'h02;
  localparam logic [7:0] CMD_TRIG  = 8'h03;
  localparam logic [7:0] CMD_CLOSE = 8'h05;

  localparam logic [GOAL_W-1:0] GOAL_SCALE = 18'd1000;

  typedef enum logic [1:0] {
    RSP_STATUS,
    RSP_OPEN,
    RSP_CLOSE
  } rsp_kind_t;

  typedef struct packed {
    logic [GOAL_W-1:0] goal;
    logic              trigger;
    logic              send;
    logic              session;
  } status_t;

  typedef struct packed {
    rsp_kind_t kind;
    status_t   st;
  } job_t;

endpackage

### rtl/core/cfpr_parser.sv
// Front end: byte window, frame match and command decode.
// Depends on cfpr_pkg; pushes one job per accepted byte into cfpr_queue.
`timescale 1ns / 1ps

module cfpr_parser
  import cfpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output job_t       job
);

  logic [7:0]        win_r   [WIN_DEPTH];
  logic [7:0]        win_nxt [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  status_t           st_r, st_nxt;
  rsp_kind_t         kind;
  logic [GOAL_W-1:0] goal;

  assign goal = GOAL_W'(GOAL_W'(win_r[3]) * GOAL_SCALE);

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    st_nxt   = st_r;
    kind     = RSP_STATUS;
    if (accept) begin
      if (fill_r < FILL_W'(WIN_DEPTH)) begin
        // append while the window is short
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (FILL_W'(i) == fill_r) begin
            win_nxt[i] = rx_byte;
          end
        end
        fill_nxt = fill_r + 1'b1;
      end else if (win_r[0] == SOF_BYTE && rx_byte == EOF_BYTE) begin
        case (win_r[1])
          CMD_OPEN: begin
            st_nxt.session = 1'b1;
            kind           = RSP_OPEN;
          end
          CMD_SEND: begin
            st_nxt.goal = goal;
            st_nxt.send = 1'b1;
          end
          CMD_TRIG: begin
            st_nxt.goal    = goal;
            st_nxt.send    = 1'b1;
            st_nxt.trigger = 1'b1;
          end
          CMD_CLOSE: begin
            st_nxt.session = 1'b0;
            kind           = RSP_CLOSE;
          end
          default: begin
          end
        endcase
        for (int i = 0; i < WIN_DEPTH; i++) begin
          win_nxt[i] = '0;
        end
        fill_nxt = '0;
      end else begin
        // drop the oldest byte
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_DEPTH-1] = rx_byte;
        fill_nxt             = FILL_W'(WIN_DEPTH);
      end
    end
    job.kind = kind;
    job.st   = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      fill_r <= '0;
      st_r   <= '0;
    end else begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
      st_r   <= st_nxt;
    end
  end

endmodule

### rtl/core/cfpr_queue.sv
// Job queue between parser and responder.
// Depends on cfpr_pkg for the job type.
`timescale 1ns / 1ps

module cfpr_queue
  import cfpr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/cfpr_responder.sv
// Back end: expands queued jobs into status results or 24-byte reply frames.
// Depends on cfpr_pkg; drives the result channel output register.
`timescale 1ns / 1ps

module cfpr_responder
  import cfpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  job_t        job,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  output logic [0:0]  out_tuser
);

  logic                   valid_r, valid_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic                   last_r, last_nxt;
  logic                   user_r, user_nxt;
  status_t                st_r, st_nxt;
  logic [FRAME_IDX_W-1:0] idx_r, idx_nxt;
  logic                   load;

  assign load = !empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    user_nxt  = user_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      st_nxt    = job.st;
      if (job.kind == RSP_STATUS) begin
        byte_nxt = '0;
        user_nxt = 1'b0;
        last_nxt = 1'b1;
        pop      = 1'b1;
      end else begin
        user_nxt = 1'b1;
        last_nxt = (idx_r == FRAME_IDX_W'(FRAME_LEN - 1));
        if (idx_r == '0) begin
          byte_nxt = RSP_SOF;
        end else if (idx_r == FRAME_IDX_W'(1)) begin
          byte_nxt = (job.kind == RSP_OPEN) ? CODE_OPEN : CODE_CLOSE;
        end else if (last_nxt) begin
          byte_nxt = EOF_BYTE;
        end else begin
          byte_nxt = '0;
        end
        // retire the job on its final byte
        pop     = last_nxt;
        idx_nxt = last_nxt ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    user_r <= user_nxt;
    st_r   <= st_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, st_r, byte_r};
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

endmodule

### rtl/core/command_frame_parser_responder.sv
// Command frame parser and responder.
// Slave channel in_* carries one received serial byte per request in in_tdata[7:0].
// The parser keeps a five-byte window; a frame FD, cmd, x, count, x, A5 is decoded:
// command 0 opens the session, 5 closes it (both answer with a 24-byte reply
// frame FE, 01/05, zeros, A5), 2 and 3 request count*1000 values, 3 also arms
// trigger mode. Any other byte yields one status result.
// Master channel out_* gives every result with the flags after that byte; out_tuser
// marks a reply frame byte and out_tlast ends the results of one input byte.
// An accepted input byte is first written into the job queue; its first result is then
// loaded into the output register that drives out_tvalid.
// The parser takes one input byte per cycle while the job queue has room; the
// responder emits one result per cycle while out_tready stays high, so a reply frame
// holds it for 24 results and a status result for one. The queue depth (QUEUE_DEPTH)
// sets how many jobs can wait. A stall on out_tready holds the output register; the
// parser keeps accepting until the queue fills, then drops in_tready.
// Reset (rst_n low, synchronous) clears the window, flags, value count and queue,
// and holds in_tready low.
`timescale 1ns / 1ps

module command_frame_parser_responder
  import cfpr_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] tx_byte, [8] session_open, [9] send_active,
                                  // [10] trigger_mode, [28:11] values_requested, [31:29] 0
  output logic        out_tlast,  // tx_last
  output logic [0:0]  out_tuser   // [0] tx_valid
);

  `include "command_frame_parser_responder_assert.svh"

  logic accept;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t push_job;
  job_t head_job;

  assign in_tready = rst_n && !q_full;
  assign accept    = in_tvalid && in_tready;

  cfpr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_tdata),
    .job     (push_job)
  );

  cfpr_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (head_job)
  );

  cfpr_responder u_responder (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .job        (head_job),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `CFPR_ASSERT_NOW(a_status_single, out_tvalid && !out_tuser[0],
                   out_tlast && out_tdata[7:0] == 8'h00,
                   "status result must be a single zero byte")
  `CFPR_ASSERT_NOW(a_frame_end, out_tvalid && out_tuser[0] && out_tlast,
                   out_tdata[7:0] == EOF_BYTE, "reply frame must end in A5")
  `CFPR_ASSERT_NEXT(a_frame_continues,
                    out_tvalid && out_tready && out_tuser[0] && !out_tlast,
                    out_tvalid && out_tuser[0], "reply frame broken off")

endmodule

### tb/sv/command_frame_parser_responder_test.sv
// Self-checking test for command_frame_parser_responder: directed command frames, then
// random frames, noise and broken frames; every result is checked against a local parser.
// Depends on cfpr_pkg and the command_frame_parser_responder RTL.
`timescale 1ns / 1ps

module command_frame_parser_responder_test;
  import cfpr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES  = 64;

  localparam logic [7:0] CMD_NOP     = 8'h04;
  localparam logic [7:0] CMD_UNKNOWN = 8'hFF;

  typedef struct {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              tx_last;
    logic              session;
    logic              send;
    logic              trigger;
    logic [GOAL_W-1:0] goal;
  } tx_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;   // [7:0] tx_byte, [8] session_open, [9] send_active,
                            // [10] trigger_mode, [28:11] values_requested, [31:29] 0
  logic        out_tlast;   // tx_last
  logic [0:0]  out_tuser;   // [0] tx_valid

  command_frame_parser_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // parser state mirrored from the block
  logic [7:0]        rx_window [WIN_DEPTH];
  int unsigned       rx_fill;
  logic              session_flag;
  logic              send_flag;
  logic              trigger_flag;
  logic [GOAL_W-1:0] value_goal;

  tx_result_t due_results[$];
  int         mismatch_count = 0;
  int         cycle = 0;
  int         burst_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic parse_rx_byte(input logic [7:0] rx);
    int unsigned fill;
    logic        has_reply;
    logic [7:0]  reply_code;
    tx_result_t  r;
    fill       = (rx_fill > WIN_DEPTH) ? WIN_DEPTH : rx_fill;
    has_reply  = 1'b0;
    reply_code = 8'h00;
    if (fill < WIN_DEPTH) begin
      rx_window[fill] = rx;
      rx_fill = fill + 1;
    end else if (rx_window[0] == SOF_BYTE && rx == EOF_BYTE) begin
      case (rx_window[1])
        CMD_OPEN: begin
          session_flag = 1'b1;
          has_reply = 1'b1;
          reply_code = CODE_OPEN;
        end
        CMD_SEND: begin
          value_goal = {{(GOAL_W-8){1'b0}}, rx_window[3]} * GOAL_SCALE;
          send_flag = 1'b1;
        end
        CMD_TRIG: begin
          value_goal = {{(GOAL_W-8){1'b0}}, rx_window[3]} * GOAL_SCALE;
          send_flag = 1'b1;
          trigger_flag = 1'b1;
        end
        CMD_CLOSE: begin
          session_flag = 1'b0;
          has_reply = 1'b1;
          reply_code = CODE_CLOSE;
        end
        default: ;
      endcase
      foreach (rx_window[i]) rx_window[i] = 8'h00;
      rx_fill = 0;
    end else begin
      // drop the oldest byte
      for (int i = 0; i < WIN_DEPTH - 1; i++) rx_window[i] = rx_window[i+1];
      rx_window[WIN_DEPTH-1] = rx;
      rx_fill = WIN_DEPTH;
    end

    r.session = session_flag;
    r.send    = send_flag;
    r.trigger = trigger_flag;
    r.goal    = value_goal;
    if (has_reply) begin
      for (int k = 0; k < FRAME_LEN; k++) begin
        r.tx_valid = 1'b1;
        r.tx_byte  = (k == 0) ? RSP_SOF : (k == 1) ? reply_code :
                     (k == FRAME_LEN - 1) ? EOF_BYTE : 8'h00;
        r.tx_last  = (k == FRAME_LEN - 1);
        due_results.push_back(r);
      end
    end else begin
      r.tx_valid = 1'b0;
      r.tx_byte  = 8'h00;
      r.tx_last  = 1'b1;
      due_results.push_back(r);
    end
  endtask

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    parse_rx_byte(b);
    burst_left--;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] arg,
                            input logic [7:0] count, input logic [7:0] pad);
    send_byte(SOF_BYTE);
    send_byte(cmd);
    send_byte(arg);
    send_byte(count);
    send_byte(pad);
    send_byte(EOF_BYTE);
  endtask

  // Hold off new requests until every result has come out.
  task automatic wait_drained;
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic test_session_open;
    // a leading stray byte makes the first six-byte check fail
    send_byte(8'hFF);
    send_frame(CMD_OPEN, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_value_requests;
    send_frame(CMD_TRIG, 8'hFF, 8'hFF, 8'hFF);
    // trigger mode must survive a plain send request
    send_frame(CMD_SEND, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_ignored_commands;
    send_frame(CMD_NOP, 8'h55, 8'h07, 8'hAA);
    send_frame(CMD_UNKNOWN, 8'hA5, 8'h33, 8'hFD);
  endtask

  task automatic test_session_close;
    send_frame(CMD_CLOSE, 8'h12, 8'h80, 8'h01);
  endtask

  task automatic test_random_traffic;
    int         sent;
    int         pick;
    logic       paused;
    logic [7:0] cmd;
    logic [7:0] last_byte;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 5))
        0:       cmd = CMD_OPEN;
        1:       cmd = CMD_SEND;
        2:       cmd = CMD_TRIG;
        3:       cmd = CMD_NOP;
        4:       cmd = CMD_CLOSE;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      if (pick < 7) begin
        send_frame(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        sent += 6;
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end else begin
        // broken frame: wrong end byte
        last_byte = 8'($urandom_range(0, 255));
        if (last_byte == EOF_BYTE) last_byte = 8'h00;
        send_byte(SOF_BYTE);
        send_byte(cmd);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        send_byte(last_byte);
        sent += 6;
      end
      if (!paused && sent >= RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    foreach (rx_window[i]) rx_window[i] = 8'h00;
    rx_fill      = 0;
    session_flag = 1'b0;
    send_flag    = 1'b0;
    trigger_flag = 1'b0;
    value_goal   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_session_open();
    test_value_requests();
    test_ignored_commands();
    test_session_close();
    test_random_traffic();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    tx_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 32'h0);
      end else begin
        want = due_results.pop_front();
        if (out_tuser[0] !== want.tx_valid)
          report_mismatch("tx_valid", out_tuser[0], want.tx_valid);
        if (out_tdata[7:0] !== want.tx_byte)
          report_mismatch("tx_byte", out_tdata[7:0], want.tx_byte);
        if (out_tlast !== want.tx_last)
          report_mismatch("tx_last", out_tlast, want.tx_last);
        if (out_tdata[8] !== want.session)
          report_mismatch("session_open", out_tdata[8], want.session);
        if (out_tdata[9] !== want.send)
          report_mismatch("send_active", out_tdata[9], want.send);
        if (out_tdata[10] !== want.trigger)
          report_mismatch("trigger_mode", out_tdata[10], want.trigger);
        if (out_tdata[28:11] !== want.goal)
          report_mismatch("values_requested", out_tdata[28:11], want.goal);
        if (out_tdata[31:29] !== 3'b000)
          report_mismatch("tdata padding", out_tdata[31:29], 32'h0);
      end
    end
    // receiver pattern: always ready, random stalls, then a fixed duty cycle
    case ((cycle / 128) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 2) != 0);
      default: out_tready <= ((cycle % 5) > 1);
    endcase
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cfpr_pkg.sv
rtl/core/cfpr_parser.sv
rtl/core/cfpr_queue.sv
rtl/core/cfpr_responder.sv
rtl/core/command_frame_parser_responder.sv
tb/sv/command_frame_parser_responder_test.sv
